FILE: hw/rtl/fqsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqsr_pkg
// shared types and codes for the searchable, reversible queue
// ----------------------------------------------------------------------------
package fqsr_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_ENQ    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ    = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OP_W-1:0] OP_REV    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_ram_ctl;

endpackage
`default_nettype wire

FILE: hw/rtl/fqsr_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqsr_ring
// ring store of queue entries, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module fqsr_ring
    import fqsr_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF,
    localparam int IW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire t_ram_ctl          i_ctl,
    input  wire logic [IW-1:0]     i_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: hw/rtl/fifo_queue_search_reverse_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_search_reverse_top
// bounded queue with enqueue, dequeue, search, reverse and clear requests
//
//   channel   direction  handshake       ports
//   request   in         start & !busy   i_operation, i_value_in
//   result    out        o_done          o_value_out, o_found, o_empty_res,
//                                        o_entry_count, o_status
//
// enqueue, reverse, clear: strobe registered from the execute state
// dequeue: strobe registered from the read state after execute, for the ring read
// search: one ring read per cycle through a shared slot adder, strobe
//   registered from the last search state; a hit ends the walk early
// busy is high from the request until the strobe; a new request may be
//   taken in the strobe cycle; reset is synchronous, store is not cleared
// ----------------------------------------------------------------------------
module fifo_queue_search_reverse_top
    import fqsr_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic        [OP_W-1:0]  i_operation,
    input  wire logic signed [VAL_W-1:0] i_value_in,
    output logic                         o_done,
    output logic signed      [VAL_W-1:0] o_value_out,
    output logic                         o_found,
    output logic                         o_empty_res,
    output logic             [CNT_W-1:0] o_entry_count,
    output logic             [ST_W-1:0]  o_status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DEQ  = 2'd2;
    localparam logic [1:0] S_SRCH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [DATA_W-1:0] r_val, n_val;
    logic [IW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_occ, n_occ;
    logic              r_rev, n_rev;
    logic [CW-1:0]     r_k, n_k;
    logic              r_done, n_done;
    logic [VAL_W-1:0]  r_vout, n_vout;
    logic              r_found, n_found;
    logic [ST_W-1:0]   r_status, n_status;
    logic              r_empty, n_empty;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              fin;
    logic [IW-1:0]     s_k;
    logic [IW:0]       sum_up;
    logic [IW:0]       dif_dn;
    logic [IW-1:0]     slot;
    logic [CW-1:0]     k_inc;
    t_ram_ctl          ram_ctl;
    logic [DATA_W-1:0] rd_data;

    // shared slot unit: ring position of the k-th entry from the front
    always_comb begin
        sum_up = {1'b0, r_head} + {1'b0, s_k};
        dif_dn = {1'b0, r_head} - {1'b0, s_k};
        if (r_rev) begin
            slot = dif_dn[IW] ? IW'(dif_dn + (IW+1)'(DEPTH)) : dif_dn[IW-1:0];
        end else begin
            slot = (sum_up >= (IW+1)'(DEPTH)) ? IW'(sum_up - (IW+1)'(DEPTH))
                                              : sum_up[IW-1:0];
        end
    end

    assign k_inc = r_k + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_head   = r_head;
        n_occ    = r_occ;
        n_rev    = r_rev;
        n_k      = r_k;
        n_done   = 1'b0;
        n_vout   = r_vout;
        n_found  = r_found;
        n_status = r_status;
        fin      = 1'b0;
        ram_ctl  = '0;
        s_k      = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_val   = DATA_W'($unsigned(i_value_in));
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_vout   = '0;
                n_found  = 1'b0;
                n_status = ST_OK;
                case (r_op)
                    OP_ENQ: begin
                        s_k = IW'(r_occ);
                        fin = 1'b1;
                        if (r_occ == CW'(DEPTH)) begin
                            n_status = ST_OVER;
                        end else begin
                            ram_ctl.wr = 1'b1;
                            n_occ      = r_occ + CW'(1);
                        end
                    end
                    OP_DEQ: begin
                        if (r_occ == '0) begin
                            n_status = ST_UNDER;
                            fin      = 1'b1;
                        end else begin
                            ram_ctl.rd = 1'b1;
                            n_state    = S_DEQ;
                        end
                    end
                    OP_SEARCH: begin
                        if (r_occ == '0) begin
                            fin = 1'b1;
                        end else begin
                            ram_ctl.rd = 1'b1;
                            n_k        = '0;
                            n_state    = S_SRCH;
                        end
                    end
                    OP_REV: begin
                        s_k   = IW'(r_occ - CW'(1));
                        fin   = 1'b1;
                        n_rev = ~r_rev;
                        if (r_occ != '0) begin
                            n_head = slot;
                        end
                    end
                    OP_CLEAR: begin
                        fin    = 1'b1;
                        n_occ  = '0;
                        n_head = '0;
                        n_rev  = 1'b0;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_DEQ: begin
                s_k    = IW'(1);
                fin    = 1'b1;
                n_vout = VAL_W'(rd_data);
                n_head = slot;
                n_occ  = r_occ - CW'(1);
            end
            S_SRCH: begin
                s_k = IW'(k_inc);
                if (rd_data == r_val) begin
                    n_found = 1'b1;
                    fin     = 1'b1;
                end else if (k_inc == r_occ) begin
                    fin = 1'b1;
                end else begin
                    ram_ctl.rd = 1'b1;
                    n_k        = k_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
            n_done  = 1'b1;
        end
        n_empty = (n_occ == '0);
        n_count = CNT_W'(n_occ);
    end

    fqsr_ring #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_addr    (slot),
        .i_wr_data (r_val),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
            r_rev   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_occ   <= n_occ;
            r_rev   <= n_rev;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_k      <= n_k;
        r_vout   <= n_vout;
        r_found  <= n_found;
        r_status <= n_status;
        r_empty  <= n_empty;
        r_count  <= n_count;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_value_out   = r_vout;
    assign o_found       = r_found;
    assign o_empty_res   = r_empty;
    assign o_entry_count = r_count;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < IW'(DEPTH) || DEPTH == (1 << IW))
        else $error("head slot outside ring");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken without going busy");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_OVER |-> r_occ == CW'(DEPTH))
        else $error("overflow reported while not full");

    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_found |-> r_op == OP_SEARCH)
        else $error("found flag on a non-search request");

    a_under_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_UNDER |-> o_empty_res && o_value_out == '0)
        else $error("underflow with entries held or nonzero data");
`endif

endmodule
`default_nettype wire
